// ===== design/icn_pkg.sv =====
// icn_pkg: shared types and constants for the chinese numeral speller
// no dependencies; compiled first

package icn_pkg;

  // binary to decimal conversion
  localparam int BIN_W      = 63;
  localparam int BCD_DIGITS = 19;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int STEP_BITS  = 3;
  localparam int CONV_STEPS = BIN_W / STEP_BITS;
  localparam int STEP_CNT_W = $clog2(CONV_STEPS);

  // decimal digit position counter
  localparam int POS_W = 5;

  typedef logic [4:0] glyph_t;
  typedef logic [1:0] style_t;

  // style codes
  localparam style_t STYLE_PLAIN   = 2'd0;
  localparam style_t STYLE_SIMPLE  = 2'd1;
  localparam style_t STYLE_FINANCE = 2'd2;
  localparam style_t STYLE_UNUSED  = 2'd3;

  // glyph code bases
  localparam glyph_t DIGIT_BASE_LOWER = 5'd0;
  localparam glyph_t DIGIT_BASE_CAP   = 5'd10;
  localparam glyph_t UNIT_BASE_LOWER  = 5'd19;
  localparam glyph_t UNIT_BASE_CAP    = 5'd22;
  localparam glyph_t MYRIAD_BASE      = 5'd22;
  localparam glyph_t GLYPH_NONE       = 5'd0;

  // top level sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SPELL,
    ST_LAUNCH,
    ST_EMIT
  } icn_state_t;

  // glyph write from the speller into the glyph store
  typedef struct packed {
    logic   valid;
    glyph_t code;
  } push_t;

endpackage

// ===== design/icn_if.sv =====
// icn_in_if / icn_out_if: valid/ready channels for numbers and glyphs
// depends on icn_pkg

interface icn_in_if import icn_pkg::*;;
  logic               valid;
  logic               ready;
  logic signed [63:0] number_value;
  style_t             style;

  modport source (output valid, output number_value, output style, input ready);
  modport sink   (input valid, input number_value, input style, output ready);
endinterface

interface icn_out_if import icn_pkg::*;;
  logic   valid;
  logic   ready;
  glyph_t glyph;
  logic   empty_res;
  logic   last;

  modport source (output valid, output glyph, output empty_res, output last, input ready);
  modport sink   (input valid, input glyph, input empty_res, input last, output ready);
endinterface

// ===== design/icn_bcd.sv =====
// icn_bcd: iterative binary to bcd converter, shift-and-add-3, three bits a cycle
// depends on icn_pkg

module icn_bcd import icn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [BIN_W-1:0] value,
  output logic             done,
  output logic [BCD_W-1:0] bcd
);

  logic [BIN_W-1:0]      bin;
  logic [STEP_CNT_W-1:0] step;
  logic                  busy;
  logic [BCD_W-1:0]      bcd_next;

  // one shift-and-add-3 step over all digits
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b, input logic bit_in);
    logic [BCD_W-1:0] adj;
    adj = b;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  // combinational chain of steps, one per bit of the shift
  always_comb begin
    bcd_next = bcd;
    for (int k = 0; k < STEP_BITS; k++) begin
      bcd_next = dabble(bcd_next, bin[BIN_W-1-k]);
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_CNT_W'(CONV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (busy) begin
      bin <= bin << STEP_BITS;
      bcd <= bcd_next;
    end
  end

endmodule

// ===== design/icn_speller.sv =====
// icn_speller: walks the decimal digits least significant first and writes glyphs
// depends on icn_pkg

module icn_speller import icn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  style_t           style,
  input  logic [BCD_W-1:0] bcd,
  output push_t            push,
  output logic             done
);

  // unit kinds
  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_TEN      = 3'd1;
  localparam logic [2:0] KIND_WAN      = 3'd4;
  localparam logic [2:0] KIND_YI       = 3'd5;
  localparam logic [2:0] KIND_ZHAO     = 3'd6;

  logic [BCD_W-1:0] remaining_value;
  logic [POS_W-1:0] digit_position;
  logic             zero_suppress;
  logic             all_zero;
  logic             phase;
  logic             active;

  logic [3:0]       d;
  logic             rest_zero;
  logic [2:0]       kind;
  logic             long_form;
  logic             persist;
  logic             zs_eff;
  logic             zs_new;
  logic             finish;
  logic             step_end;
  glyph_t           dbase;
  glyph_t           ubase;
  glyph_t           p0;
  glyph_t           p1;
  logic [1:0]       pc;
  glyph_t           g0;
  glyph_t           g1;
  logic [1:0]       n_glyph;

  // unit glyph that follows a digit at a given position
  function automatic logic [2:0] unit_kind(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] q;
    logic [2:0]       r;
    logic [2:0]       k;
    q = p;
    r = '0;
    if (p == '0) begin
      k = KIND_NONE;
    end else if (p == POS_W'(12) || p == POS_W'(24)) begin
      k = KIND_ZHAO;
    end else begin
      if (p > POS_W'(24)) q = p - POS_W'(24);
      else if (p > POS_W'(12)) q = p - POS_W'(12);
      if (q == POS_W'(8)) begin
        k = KIND_YI;
      end else begin
        r = q[2:0];
        if (r == 3'd4) k = KIND_WAN;
        else k = {1'b0, r[1:0]};
      end
    end
    return k;
  endfunction

  // glyphs caused by the current digit
  always_comb begin
    d         = remaining_value[3:0];
    rest_zero = (remaining_value[BCD_W-1:4] == '0);
    kind      = unit_kind(digit_position);
    long_form = (style == STYLE_SIMPLE) || (style == STYLE_FINANCE);
    persist   = (kind == KIND_NONE) || (kind >= KIND_WAN);
    zs_eff    = persist | zero_suppress;
    dbase     = (style == STYLE_FINANCE) ? DIGIT_BASE_CAP : DIGIT_BASE_LOWER;
    ubase     = (style == STYLE_FINANCE) ? UNIT_BASE_CAP : UNIT_BASE_LOWER;
    p0        = GLYPH_NONE;
    p1        = GLYPH_NONE;
    pc        = 2'd0;
    g0        = glyph_t'(d);
    g1        = GLYPH_NONE;
    n_glyph   = 2'd1;
    zs_new    = zero_suppress;
    finish    = rest_zero;
    if (!long_form) begin
      // plain digits: defaults hold
    end else if (all_zero) begin
      finish  = 1'b1;
      g0      = DIGIT_BASE_CAP;
      n_glyph = (style == STYLE_FINANCE) ? 2'd1 : 2'd0;
    end else begin
      // digit part
      if (d == 4'd0) begin
        zs_new = 1'b1;
        if (!zs_eff) begin
          p0 = dbase;
          pc = 2'd1;
        end
      end else begin
        zs_new = 1'b0;
        if (rest_zero && d == 4'd1 && kind == KIND_TEN) begin
          p0 = ubase + 5'd1;
          pc = 2'd1;
        end else if (persist) begin
          p0 = dbase + glyph_t'(d);
          pc = 2'd1;
        end else begin
          p0 = ubase + glyph_t'(kind);
          p1 = dbase + glyph_t'(d);
          pc = 2'd2;
        end
      end
      // myriad unit goes out ahead of the digit part
      if (kind >= KIND_WAN) begin
        g0      = MYRIAD_BASE + glyph_t'(kind);
        g1      = p0;
        n_glyph = pc + 2'd1;
      end else begin
        g0      = p0;
        g1      = p1;
        n_glyph = pc;
      end
    end
  end

  // glyph write and completion
  always_comb begin
    step_end   = phase || (n_glyph != 2'd2);
    push.valid = active && (phase || (n_glyph != 2'd0));
    push.code  = phase ? g1 : g0;
    done       = active && step_end && finish;
  end

  // digit sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      active          <= 1'b0;
      phase           <= 1'b0;
      remaining_value <= '0;
      digit_position  <= '0;
      zero_suppress   <= 1'b0;
      all_zero        <= 1'b0;
    end else if (start) begin
      active          <= 1'b1;
      phase           <= 1'b0;
      remaining_value <= bcd;
      digit_position  <= '0;
      zero_suppress   <= 1'b0;
      all_zero        <= (bcd == '0);
    end else if (active) begin
      phase <= ~step_end;
      if (step_end) begin
        if (finish) begin
          active <= 1'b0;
        end else begin
          remaining_value <= remaining_value >> 4;
          digit_position  <= digit_position + 1'b1;
          zero_suppress   <= zs_new;
        end
      end
    end
  end

endmodule

// ===== design/icn_glyph_buf.sv =====
// icn_glyph_buf: circular glyph store, read back most significant first
// depends on icn_pkg and icn_out_if

module icn_glyph_buf import icn_pkg::*; #(
  parameter int MAX_GLYPHS = 38
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             start_read,
  input  push_t            push,
  output logic             busy,
  icn_out_if.source        out_ch
);

  localparam int IDX_W = $clog2(MAX_GLYPHS);
  localparam int CNT_W = $clog2(MAX_GLYPHS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_GLYPHS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_GLYPHS);

  glyph_t           glyph_store [MAX_GLYPHS];
  glyph_t           rd_data;
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [IDX_W-1:0] rd_ptr_next;
  logic [CNT_W-1:0] glyph_count;
  logic [CNT_W-1:0] left;
  logic             empty_mode;
  logic             load;

  // output register free or being drained
  assign load = busy && (!out_ch.valid || out_ch.ready);

  // read address walks down from the newest entry
  always_comb begin
    rd_ptr_next = rd_ptr;
    if (start_read) begin
      rd_ptr_next = (wr_ptr == '0) ? LAST_IDX : wr_ptr - 1'b1;
    end else if (load && !empty_mode) begin
      rd_ptr_next = (rd_ptr == '0) ? LAST_IDX : rd_ptr - 1'b1;
    end
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (push.valid) begin
      glyph_store[wr_ptr] <= push.code;
    end
    rd_data <= glyph_store[rd_ptr_next];
    rd_ptr  <= rd_ptr_next;
  end

  // fill and readout control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr       <= '0;
      glyph_count  <= '0;
      busy         <= 1'b0;
      left         <= '0;
      empty_mode   <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (clear) begin
        wr_ptr      <= '0;
        glyph_count <= '0;
      end else if (push.valid) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
        if (glyph_count != FULL_CNT) begin
          glyph_count <= glyph_count + 1'b1;
        end
      end
      if (start_read) begin
        busy       <= 1'b1;
        left       <= glyph_count;
        empty_mode <= (glyph_count == '0);
      end else if (load) begin
        left <= left - 1'b1;
        if (empty_mode || left == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
      if (load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // output transaction payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.glyph     <= empty_mode ? GLYPH_NONE : rd_data;
      out_ch.empty_res <= empty_mode;
      out_ch.last      <= empty_mode || (left == CNT_W'(1));
    end
  end

endmodule

// ===== design/integer_to_chinese_numerals.sv =====
// Chinese numeral speller: takes one signed 64-bit number and a style and sends
// its glyph codes most significant first, one output transaction per glyph, with
// last on the final one; a negative number, style 3 or zero in simplified style
// gives a single transaction with empty_res set. One number at a time: the binary
// to decimal shifter takes three bits a cycle, the digit walk steps through the
// decimal digits and writes a digit's two glyphs one after the other (the store
// has one write port), then glyphs leave at one per cycle while the sink is ready.
// depends on icn_pkg, icn_if, icn_bcd, icn_speller, icn_glyph_buf

module integer_to_chinese_numerals import icn_pkg::*; #(
  parameter int MAX_GLYPHS = 38
) (
  input  logic      clk,
  input  logic      rst,
  icn_in_if.sink    number_ch,
  icn_out_if.source glyph_ch
);

  icn_state_t       state;
  icn_state_t       state_next;
  style_t           style_q;
  logic             accept;
  logic             empty_path;
  logic             bcd_start;
  logic             bcd_done;
  logic [BCD_W-1:0] bcd;
  logic             spell_start;
  logic             spell_done;
  logic             start_read;
  logic             buf_busy;
  push_t            push;

  assign accept     = number_ch.valid && number_ch.ready;
  assign empty_path = number_ch.number_value[63] || (number_ch.style == STYLE_UNUSED);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (accept) state_next = empty_path ? ST_LAUNCH : ST_CONVERT;
      ST_CONVERT: if (bcd_done) state_next = ST_SPELL;
      ST_SPELL:   if (spell_done) state_next = ST_LAUNCH;
      ST_LAUNCH:  state_next = ST_EMIT;
      ST_EMIT:    if (!buf_busy) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    number_ch.ready = (state == ST_IDLE);
    bcd_start       = accept && !empty_path;
    spell_start     = (state == ST_CONVERT) && bcd_done;
    start_read      = (state == ST_LAUNCH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // style held for the digit walk
  always_ff @(posedge clk) begin
    if (accept) begin
      style_q <= number_ch.style;
    end
  end

  icn_bcd u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (bcd_start),
    .value (number_ch.number_value[BIN_W-1:0]),
    .done  (bcd_done),
    .bcd   (bcd)
  );

  icn_speller u_speller (
    .clk   (clk),
    .rst   (rst),
    .start (spell_start),
    .style (style_q),
    .bcd   (bcd),
    .push  (push),
    .done  (spell_done)
  );

  icn_glyph_buf #(
    .MAX_GLYPHS (MAX_GLYPHS)
  ) u_glyph_buf (
    .clk        (clk),
    .rst        (rst),
    .clear      (accept),
    .start_read (start_read),
    .push       (push),
    .busy       (buf_busy),
    .out_ch     (glyph_ch)
  );

endmodule

// ===== design/icn_checker.sv =====
// icn_checker: port-level checks on the chinese numeral speller, bound to the top
// depends on icn_pkg and integer_to_chinese_numerals

module icn_checker import icn_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input glyph_t glyph,
  input logic   empty_res,
  input logic   last
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(glyph) && $stable(empty_res)
      && $stable(last))
    else $error("output transaction changed while stalled");

  // one number at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transaction");

  // empty result is a single zero transaction
  a_empty_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> last && glyph == GLYPH_NONE)
    else $error("empty result not a single zero transaction");

  // glyph codes stay within the code set
  a_glyph_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> glyph <= 5'd28)
    else $error("glyph code out of range");

endmodule

bind integer_to_chinese_numerals icn_checker u_icn_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (number_ch.valid),
  .in_ready  (number_ch.ready),
  .out_valid (glyph_ch.valid),
  .out_ready (glyph_ch.ready),
  .glyph     (glyph_ch.glyph),
  .empty_res (glyph_ch.empty_res),
  .last      (glyph_ch.last)
);
